### hw/rtl/tseb_pkg.sv
// Types and codes shared by the time sorted event buffer.
`default_nettype none

package tseb_pkg;

   // Longest payload accepted, in bytes
   localparam logic [2:0] MAX_BYTES = 3'd3;

   // Input channel widths
   localparam int unsigned ReqDataWidth = 64;
   localparam int unsigned ReqUserWidth = 2;
   // Result channel widths
   localparam int unsigned RspDataWidth = 64;
   localparam int unsigned RspUserWidth = 2;

   typedef enum logic [1:0] {
      CMD_INSERT = 2'd0,
      CMD_CLEAR  = 2'd1,
      CMD_READ   = 2'd2
   } command_type;

   typedef enum logic [1:0] {
      STS_OK         = 2'd0,
      STS_FULL       = 2'd1,
      STS_NOT_FILLED = 2'd2,
      STS_TOO_LONG   = 2'd3
   } status_type;

   // One stored event, frame in the top bits
   typedef struct packed {
      logic signed [31:0] frame;
      logic        [1:0]  length;
      logic        [23:0] payload;
   } entry_type;

endpackage : tseb_pkg

`default_nettype wire

### hw/rtl/time_sorted_event_buffer.sv
// Top level of the time sorted event buffer: sequencer, compare unit and result register.
`default_nettype none

// Holds up to DEPTH short events sorted by signed frame number in one RAM.
// Each item on the req_ channel carries a command in req_tuser (insert,
// clear or read) and gives exactly one item on the rsp_ channel with a
// status in rsp_tuser. An insert walks the store from the top entry down
// through a single frame comparator, moving each later entry up one place
// per cycle; a new event goes ahead of held events with the same frame. The
// RAM read port, one address per cycle, sets the walk rate. req_tready is
// high only between commands; a finished item waits in the rsp_ register
// while the next command is taken. An insert into a full store, or with a
// length above three bytes, leaves the store as it was.
module time_sorted_event_buffer #(
   parameter int unsigned DEPTH = 16
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // Input channel
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   // frame[31:0], length[33:32], payload[57:34], position[61:58], zero[63:62]
   input  wire logic [tseb_pkg::ReqDataWidth-1:0]  req_tdata,
   // command[1:0]
   input  wire logic [tseb_pkg::ReqUserWidth-1:0]  req_tuser,
   // Result channel
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   // fill_count[4:0], out_frame[36:5], out_length[38:37], out_payload[62:39],
   // zero[63]
   output logic      [tseb_pkg::RspDataWidth-1:0]  rsp_tdata,
   // status[1:0]
   output logic      [tseb_pkg::RspUserWidth-1:0]  rsp_tuser
);

   import tseb_pkg::*;

   localparam int unsigned AW = $clog2(DEPTH);
   localparam int unsigned CW = $clog2(DEPTH + 1);
   localparam int unsigned EW = $bits(entry_type);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_SCAN  = 5'b00010,
      ST_PUT   = 5'b00100,
      ST_FETCH = 5'b01000,
      ST_DONE  = 5'b10000
   } state_type;

   state_type                 state_ff, state_in;
   logic [CW-1:0]             count_ff, count_in;
   logic [AW-1:0]             idx_ff, idx_in;
   entry_type                 new_ff, new_in;
   entry_type                 res_ff, res_in;
   status_type                status_ff, status_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [RspDataWidth-1:0]   rsp_data_ff, rsp_data_in;
   logic [RspUserWidth-1:0]   rsp_user_ff, rsp_user_in;

   logic                      wr_en;
   logic [AW-1:0]             wr_addr;
   entry_type                 wr_data;
   logic [AW-1:0]             rd_addr;
   entry_type                 rd_data;
   logic [EW-1:0]             rd_word;

   // Input fields
   command_type               req_command;
   logic signed [31:0]        req_frame;
   logic [1:0]                req_length;
   logic [23:0]               req_payload;
   logic [3:0]                req_position;
   logic [23:0]               masked_payload;

   // Count and position compared at a common width
   logic [8:0]                count_wide;
   logic [8:0]                pos_wide;
   logic [CW-1:0]             count_less;
   logic                      entry_not_before;

   assign req_command  = command_type'(req_tuser);
   assign req_frame    = req_tdata[31:0];
   assign req_length   = req_tdata[33:32];
   assign req_payload  = req_tdata[57:34];
   assign req_position = req_tdata[61:58];

   assign count_wide = 9'(count_ff);
   assign pos_wide   = 9'(req_position);
   assign count_less = count_ff - CW'(1);

   // Keep only the bytes that the length covers
   always_comb begin
      masked_payload = '0;
      for (int b = 0; b < 3; b++) begin
         if (2'(b) < req_length) begin
            masked_payload[8*b +: 8] = req_payload[8*b +: 8];
         end
      end
   end

   // Shared compare unit: stored frame not below the new one
   assign entry_not_before = (rd_data.frame >= new_ff.frame);

   assign rd_data = entry_type'(rd_word);

   tseb_ram #(
      .WIDTH (EW),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (EW'(wr_data)),
      .rd_addr (rd_addr),
      .rd_data (rd_word)
   );

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      new_in       = new_ff;
      res_in       = res_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      wr_en        = 1'b0;
      wr_addr      = idx_ff + AW'(1);
      wr_data      = new_ff;
      rd_addr      = idx_ff - AW'(1);

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               new_in.frame   = req_frame;
               new_in.length  = req_length;
               new_in.payload = masked_payload;
               res_in         = '0;
               status_in      = STS_OK;
               state_in       = ST_DONE;
               unique case (req_command)
                  CMD_INSERT: begin
                     if (3'(req_length) > MAX_BYTES) begin
                        status_in = STS_TOO_LONG;
                     end else if (count_wide == 9'(DEPTH)) begin
                        status_in = STS_FULL;
                     end else if (count_ff == '0) begin
                        state_in = ST_PUT;
                     end else begin
                        // Start the walk at the top held entry
                        rd_addr  = count_less[AW-1:0];
                        idx_in   = count_less[AW-1:0];
                        state_in = ST_SCAN;
                     end
                  end
                  CMD_CLEAR: begin
                     count_in = '0;
                  end
                  CMD_READ: begin
                     if (pos_wide < count_wide) begin
                        rd_addr  = pos_wide[AW-1:0];
                        state_in = ST_FETCH;
                     end else begin
                        status_in = STS_NOT_FILLED;
                     end
                  end
                  default: begin
                     status_in = STS_OK;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            wr_en = 1'b1;
            if (entry_not_before) begin
               // Move the entry up one place and step down
               wr_data = rd_data;
               if (idx_ff == '0) begin
                  state_in = ST_PUT;
               end else begin
                  idx_in = idx_ff - AW'(1);
               end
            end else begin
               // Drop the new event in just above this entry
               count_in = count_ff + CW'(1);
               state_in = ST_DONE;
            end
         end
         ST_PUT: begin
            wr_en    = 1'b1;
            wr_addr  = '0;
            count_in = count_ff + CW'(1);
            state_in = ST_DONE;
         end
         ST_FETCH: begin
            res_in   = rd_data;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // Hand over the item once the result register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {1'b0, res_ff.payload, res_ff.length, res_ff.frame,
                               count_wide[4:0]};
               rsp_user_in  = status_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      new_ff      <= new_in;
      res_ff      <= res_in;
      status_ff   <= status_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule : time_sorted_event_buffer

`default_nettype wire

### hw/rtl/tseb_ram.sv
// Generic single write port RAM with one registered read port.
`default_nettype none

module tseb_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write one word; read one word into a registered output
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule : tseb_ram

`default_nettype wire

### tb/time_sorted_event_buffer_checker.sv
// Checker for the time sorted event buffer: predicts every result and compares it.
`timescale 1ns / 100ps

module tseb_result_checker #(
   parameter int unsigned DEPTH = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   input  logic                               req_tready,
   input  logic [tseb_pkg::ReqDataWidth-1:0]  req_tdata,
   input  logic [tseb_pkg::ReqUserWidth-1:0]  req_tuser,
   input  logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   input  logic [tseb_pkg::RspDataWidth-1:0]  rsp_tdata,
   input  logic [tseb_pkg::RspUserWidth-1:0]  rsp_tuser,
   output int                                 mismatch_count,
   output int                                 awaited_count,
   output int                                 full_refusals,
   output int                                 filled_reads,
   output int                                 commands_seen
);

   import tseb_pkg::*;

   // One result item, field by field
   typedef struct packed {
      logic [1:0]         status;
      logic [4:0]         fill;
      logic signed [31:0] frame;
      logic [1:0]         length;
      logic [23:0]        payload;
   } outcome_type;

   // Own copy of the sorted store
   entry_type   sorted_events [DEPTH];
   int          held_events;
   outcome_type awaited_results [$];

   // Apply one command to the store copy and return the result it gives
   function automatic outcome_type predict_outcome(input logic [1:0] cmd,
                                                   input logic signed [31:0] frm,
                                                   input logic [1:0] len,
                                                   input logic [23:0] pay,
                                                   input logic [3:0] pos);
      outcome_type res;
      int          at;
      logic [23:0] keep_mask;
      res = '0;
      res.status = STS_OK;
      case (cmd)
         CMD_INSERT: begin
            if ({1'b0, len} > MAX_BYTES) begin
               res.status = STS_TOO_LONG;
            end else if (held_events >= DEPTH) begin
               res.status = STS_FULL;
               full_refusals++;
            end else begin
               // find the first held event not below the new frame
               at = 0;
               while (at < held_events && $signed(sorted_events[at].frame) < frm) at++;
               for (int slot = held_events; slot > at; slot--)
                  sorted_events[slot] = sorted_events[slot-1];
               // keep only the bytes the length covers
               keep_mask = 24'hFF_FFFF >> (24 - 8 * int'(len));
               sorted_events[at].frame   = frm;
               sorted_events[at].length  = len;
               sorted_events[at].payload = pay & keep_mask;
               held_events++;
            end
         end
         CMD_CLEAR: begin
            held_events = 0;
         end
         CMD_READ: begin
            if (pos < held_events) begin
               res.frame   = sorted_events[pos].frame;
               res.length  = sorted_events[pos].length;
               res.payload = sorted_events[pos].payload;
               filled_reads++;
            end else begin
               res.status = STS_NOT_FILLED;
            end
         end
         default: begin
         end
      endcase
      res.fill = held_events[4:0];
      return res;
   endfunction

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         mismatch_count++;
         $display("%0t: %s expected %0h got %0h", $time, name, want, got);
      end
   endtask

   // Compare results first, then log the command taken at the same edge
   always @(posedge clock) begin : watch_channels
      outcome_type seen;
      outcome_type want;
      if (reset) begin
         held_events = 0;
         awaited_results.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            seen.status  = rsp_tuser[1:0];
            seen.fill    = rsp_tdata[4:0];
            seen.frame   = rsp_tdata[36:5];
            seen.length  = rsp_tdata[38:37];
            seen.payload = rsp_tdata[62:39];
            if (awaited_results.size() == 0) begin
               mismatch_count++;
               $display("%0t: result with no command waiting, expected none got %0h",
                        $time, seen);
            end else begin
               want = awaited_results.pop_front();
               check_field("status", want.status, seen.status);
               check_field("fill_count", want.fill, seen.fill);
               check_field("out_frame", want.frame, seen.frame);
               check_field("out_length", want.length, seen.length);
               check_field("out_payload", want.payload, seen.payload);
            end
         end
         if (req_tvalid && req_tready) begin
            awaited_results.push_back(predict_outcome(req_tuser[1:0], req_tdata[31:0],
                                                      req_tdata[33:32], req_tdata[57:34],
                                                      req_tdata[61:58]));
            commands_seen++;
         end
      end
      awaited_count = awaited_results.size();
   end

endmodule

### tb/tb_time_sorted_event_buffer.sv
// Top of the time sorted event buffer testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_time_sorted_event_buffer;

   import tseb_pkg::*;

   localparam int unsigned Depth      = 16;
   localparam logic [1:0]  CMD_UNUSED = 2'd3;
   localparam int          MaxGap     = 18;
   localparam int          ItemTarget = 1200;

   logic                     clock      = 1'b0;
   logic                     reset      = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic [ReqDataWidth-1:0]  req_tdata  = '0;
   logic [ReqUserWidth-1:0]  req_tuser  = '0;
   logic                     rsp_tready = 1'b0;
   wire                      req_tready;
   wire                      rsp_tvalid;
   wire  [RspDataWidth-1:0]  rsp_tdata;
   wire  [RspUserWidth-1:0]  rsp_tuser;

   bit steady_flow = 1'b0;
   int items_sent  = 0;
   int mismatches;
   int awaited;
   int refusals;
   int filled_reads;
   int commands;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   time_sorted_event_buffer #(.DEPTH(Depth)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   tseb_result_checker #(.DEPTH(Depth)) result_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .mismatch_count (mismatches),
      .awaited_count  (awaited),
      .full_refusals  (refusals),
      .filled_reads   (filled_reads),
      .commands_seen  (commands)
   );

   function automatic int draw_gap();
      return steady_flow ? 0 : $urandom_range(0, MaxGap);
   endfunction

   // Frames bunched near zero for ties, at the extremes, or anywhere
   function automatic logic signed [31:0] pick_frame();
      case ($urandom_range(0, 9))
         0:       return 32'sh8000_0000;
         1:       return 32'sh7FFF_FFFF;
         2, 3, 4: return $signed($urandom_range(0, 8)) - 4;
         5:       return 32'sh8000_0000 + $urandom_range(0, 3);
         6:       return 32'sh7FFF_FFFF - $urandom_range(0, 3);
         default: return $urandom;
      endcase
   endfunction

   // Offer one item after a random gap and hold it until taken
   task automatic send_item(input logic [1:0] cmd, input logic signed [31:0] frm,
                            input logic [1:0] len, input logic [23:0] pay,
                            input logic [3:0] pos);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {2'b00, pos, pay, len, frm};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (cmd != CMD_UNUSED) items_sent++;
   endtask

   // Drain results with random stalls
   initial begin : drain_results
      int gap;
      wait (!reset);
      @(posedge clock);
      forever begin
         gap = draw_gap();
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
      end
   end

   initial begin : run_stimulus
      int         burst_len;
      int         insert_share;
      int         roll;
      logic [1:0] cmd;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // read from an empty store
      send_item(CMD_READ, 32'sd0, 2'd0, 24'h0, 4'd0);
      // extremes of frame, zero length, masked payload bytes, equal frames
      send_item(CMD_INSERT, 32'sh7FFF_FFFF, 2'd3, 24'hFF_FFFF, 4'hF);
      send_item(CMD_INSERT, 32'sh8000_0000, 2'd0, 24'hFF_FFFF, 4'hF);
      send_item(CMD_INSERT, 32'sd0, 2'd1, 24'hAB_CDEF, 4'd0);
      send_item(CMD_INSERT, 32'sd0, 2'd2, 24'h12_3456, 4'd0);
      send_item(CMD_INSERT, -32'sd1, 2'd3, 24'h00_0001, 4'd0);
      send_item(CMD_INSERT, 32'sh7FFF_FFFF, 2'd1, 24'h5A_5A5A, 4'd0);
      for (int p = 0; p < 7; p++) send_item(CMD_READ, 32'sd0, 2'd0, 24'h0, p[3:0]);
      send_item(CMD_READ, 32'sd0, 2'd0, 24'h0, 4'hF);
      // unused command leaves the store alone
      send_item(CMD_UNUSED, 32'sh7FFF_FFFF, 2'd3, 24'hFF_FFFF, 4'hF);
      send_item(CMD_READ, 32'sd0, 2'd0, 24'h0, 4'd5);
      send_item(CMD_CLEAR, 32'sd0, 2'd0, 24'h0, 4'd0);
      send_item(CMD_READ, 32'sd0, 2'd0, 24'h0, 4'd0);

      // random bursts, insert heavy enough to fill the store now and then
      while (items_sent < ItemTarget) begin
         burst_len    = $urandom_range(4, 32);
         insert_share = $urandom_range(35, 95);
         steady_flow  = ($urandom_range(0, 4) == 0);
         for (int k = 0; k < burst_len; k++) begin
            roll = $urandom_range(0, 99);
            if (roll < insert_share)
               cmd = CMD_INSERT;
            else if (roll < 97)
               cmd = CMD_READ;
            else if (roll < 99)
               cmd = CMD_UNUSED;
            else
               cmd = CMD_CLEAR;
            send_item(cmd, pick_frame(), 2'($urandom_range(0, 3)), 24'($urandom),
                      4'($urandom_range(0, 15)));
         end
         if ($urandom_range(0, 3) != 0)
            send_item(CMD_CLEAR, $urandom, 2'($urandom_range(0, 3)), 24'($urandom),
                      4'($urandom_range(0, 15)));
      end
      req_tvalid <= 1'b0;

      // wait for the last results, then allow a full insert walk
      @(posedge clock);
      wait (awaited == 0);
      repeat (40) @(posedge clock);

      $display("covered %0d commands, %0d inserts refused on a full store,",
               commands, refusals);
      $display("and %0d reads of held events", filled_reads);
      if (mismatches == 0 && awaited == 0)
         $display("tb_time_sorted_event_buffer: clean");
      else
         $display("tb_time_sorted_event_buffer: errors");
      $finish;
   end

   // Stop a hung run
   initial begin : watchdog
      #20_000_000;
      $display("timed out with %0d results outstanding", awaited);
      $display("tb_time_sorted_event_buffer: errors");
      $finish;
   end

endmodule
